[src/xxtea_ctr_frame_crypt_unit_assert.svh]
// assertion macros for the xxtea counter-mode frame unit
`ifndef XXTEA_CTR_FRAME_CRYPT_UNIT_ASSERT_SVH
`define XXTEA_CTR_FRAME_CRYPT_UNIT_ASSERT_SVH

// implication checked every clock, quiet during reset
`define XFC_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// implication whose consequent is checked on the next clock
`define XFC_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

[src/xcf_pkg.sv]
// shared types and constants for the xxtea counter-mode frame unit
`timescale 1ns / 1ps
package xcf_pkg;
    localparam int unsigned WINDOW_DEF     = 32;
    localparam int unsigned MAX_FRAME_DEF  = 32;
    localparam int unsigned ADDR_BYTES_DEF = 5;

    localparam logic [31:0] DELTA  = 32'h9E3779B9;
    localparam int unsigned ROUNDS = 6 + 52 / 2;

    localparam logic [1:0] OP_SEAL   = 2'd0;
    localparam logic [1:0] OP_OPEN   = 2'd1;
    localparam logic [1:0] OP_FORGET = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADLEN = 2'd1;
    localparam logic [1:0] ST_REPLAY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CTRB,
        S_KEYS,
        S_READ,
        S_EMIT
    } t_state;

    // request to the keystream engine and its reply
    typedef struct packed {
        logic        start;
        logic [31:0] ctr;
    } t_ks_req;

    typedef struct packed {
        logic        done;
        logic [63:0] ks;
    } t_ks_rsp;

    function automatic logic [31:0] mix(input logic [31:0] y, input logic [31:0] z,
                                        input logic [31:0] sum, input logic [31:0] k);
        mix = (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^ ((sum ^ y) + (k ^ z));
    endfunction
endpackage

[src/xcf_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module xcf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/xcf_keystream.sv]
// xxtea keystream engine, one round per clock
`timescale 1ns / 1ps
module xcf_keystream (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [127:0]      i_key,
    input  xcf_pkg::t_ks_req  i_req,
    output xcf_pkg::t_ks_rsp  o_rsp
);
    localparam int unsigned RW = $clog2(xcf_pkg::ROUNDS + 1);

    logic [31:0]   r_v0, r_v1, r_sum;
    logic [RW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [31:0]   n_v0, n_v1, n_sum, k0, k1;
    logic [1:0]    e;

    always_comb begin
        n_sum = r_sum + xcf_pkg::DELTA;
        e     = n_sum[3:2];
        k0    = i_key[127 - 32 * {30'd0, e} -: 32];
        k1    = i_key[127 - 32 * {30'd0, e ^ 2'd1} -: 32];
        n_v0  = r_v0 + xcf_pkg::mix(r_v1, r_v1, n_sum, k0);
        n_v1  = r_v1 + xcf_pkg::mix(n_v0, n_v0, n_sum, k1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == RW'(xcf_pkg::ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_v0  <= i_req.ctr;
            r_v1  <= ~i_req.ctr;
            r_sum <= '0;
        end else if (r_busy) begin
            r_v0  <= n_v0;
            r_v1  <= n_v1;
            r_sum <= n_sum;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ks   = {r_v0, r_v1};
endmodule

[src/xxtea_ctr_frame_crypt_unit.sv]
// top level: frame buffer, counters and output sequencer
`timescale 1ns / 1ps
// Frame bytes are taken one per request while busy is low; a byte that does not end a
// frame leaves busy low. On a frame end the unit goes busy and emits results, one per
// strobe, which the receiver must take as they come. Each group of up to eight bytes
// needs a fresh keystream block of 32 XXTEA rounds at one round per cycle, then one
// frame-buffer read per byte through the registered read port. An error result is
// emitted alone, with no keystream or buffer read. The frame buffer needs no clearing
// after reset.
module xxtea_ctr_frame_crypt_unit #(
    parameter int unsigned WINDOW     = xcf_pkg::WINDOW_DEF,
    parameter int unsigned MAX_FRAME  = xcf_pkg::MAX_FRAME_DEF,
    parameter int unsigned ADDR_BYTES = xcf_pkg::ADDR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    input  logic        i_cfg_we,
    input  logic [39:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [1:0]  o_status
);
    `include "xxtea_ctr_frame_crypt_unit_assert.svh"

    localparam int unsigned AW = $clog2(MAX_FRAME);
    localparam int unsigned CW = $clog2(MAX_FRAME + 2);

    xcf_pkg::t_state r_state, n_state;
    logic [39:0]   r_addr;
    logic [127:0]  key;
    logic [31:0]   r_send, r_recv, r_ctr;
    logic          r_synced;
    logic [CW-1:0] r_cnt, r_len, r_idx;
    logic          r_open;
    logic [2:0]    r_ksi;
    logic [63:0]   r_ks;
    logic          r_rdv;
    logic          r_err;
    logic [1:0]    r_errst;
    logic [7:0]    rdata;
    xcf_pkg::t_ks_req ks_req;
    xcf_pkg::t_ks_rsp ks_rsp;

    logic       acc, store, fin;
    logic [CW-1:0] len_now;
    logic       bad_len, win_bad;
    logic [7:0] cb_diff;
    logic [31:0] open_ctr;
    logic [7:0] r_first;
    logic [7:0] first_now;
    logic [CW-1:0] last_idx;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            key[127 - 8 * i -: 8] =
                r_addr[8 * (ADDR_BYTES - 1 - (i % ADDR_BYTES)) +: 8];
        end
    end

    assign acc   = start && !busy;
    assign store = acc && (i_op == xcf_pkg::OP_SEAL || i_op == xcf_pkg::OP_OPEN);
    assign fin   = store && i_frame_end;
    assign len_now = (r_cnt < CW'(MAX_FRAME)) ? r_cnt + 1'b1 : CW'(MAX_FRAME + 1);
    assign bad_len = (i_op == xcf_pkg::OP_SEAL)
        ? (len_now < CW'(2) || len_now > CW'(MAX_FRAME - 1))
        : (len_now < CW'(3) || len_now > CW'(MAX_FRAME));

    // first frame byte is captured on the side so the window test needs no read
    assign first_now = (r_cnt == '0) ? i_data_byte : r_first;
    assign cb_diff   = first_now - r_recv[7:0];
    assign win_bad   = r_synced && (cb_diff == 8'd0 || {24'd0, cb_diff} > 32'(WINDOW));
    always_comb begin
        if (!r_synced) begin
            open_ctr = {24'd0, first_now};
        end else begin
            open_ctr = {r_recv[31:8], first_now};
            if (first_now < r_recv[7:0]) begin
                open_ctr = open_ctr + 32'd256;
            end
        end
    end

    // open frames index the buffer from one, so the last byte sits at r_len
    assign last_idx = r_open ? r_len : r_len - 1'b1;

    xcf_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_store (
        .i_clk   (i_clk),
        .i_we    (store && r_cnt < CW'(MAX_FRAME)),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    xcf_keystream u_ks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key),
        .i_req   (ks_req),
        .o_rsp   (ks_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xcf_pkg::S_IDLE: begin
                if (fin) begin
                    if (bad_len || (i_op == xcf_pkg::OP_OPEN && win_bad)) begin
                        n_state = xcf_pkg::S_EMIT;
                    end else if (i_op == xcf_pkg::OP_SEAL) begin
                        n_state = xcf_pkg::S_CTRB;
                    end else begin
                        n_state = xcf_pkg::S_KEYS;
                    end
                end
            end
            xcf_pkg::S_CTRB: n_state = xcf_pkg::S_KEYS;
            xcf_pkg::S_KEYS: if (ks_rsp.done) n_state = xcf_pkg::S_READ;
            xcf_pkg::S_READ: n_state = xcf_pkg::S_EMIT;
            xcf_pkg::S_EMIT: begin
                if (r_err || r_idx == last_idx) begin
                    n_state = xcf_pkg::S_IDLE;
                end else if (r_ksi == 3'd7) begin
                    n_state = xcf_pkg::S_KEYS;
                end else begin
                    n_state = xcf_pkg::S_READ;
                end
            end
            default: n_state = xcf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ks_req.start = (r_state == xcf_pkg::S_KEYS) && !r_rdv;
        ks_req.ctr   = r_ctr;
        busy         = (r_state != xcf_pkg::S_IDLE);
        o_valid      = 1'b0;
        o_out_byte   = 8'd0;
        o_out_last   = 1'b0;
        o_status     = xcf_pkg::ST_OK;
        if (r_state == xcf_pkg::S_CTRB) begin
            o_valid    = 1'b1;
            o_out_byte = r_ctr[7:0];
        end else if (r_state == xcf_pkg::S_EMIT) begin
            o_valid = 1'b1;
            if (r_err) begin
                o_out_last = 1'b1;
                o_status   = r_errst;
            end else begin
                o_out_byte = rdata ^ r_ks[63 - 8 * r_ksi -: 8];
                o_out_last = (r_idx == last_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= xcf_pkg::S_IDLE;
            r_addr   <= '0;
            r_send   <= '0;
            r_recv   <= '0;
            r_synced <= 1'b0;
            r_cnt    <= '0;
            r_rdv    <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_addr   <= i_cfg_wdata;
                r_send   <= '0;
                r_recv   <= '0;
                r_synced <= 1'b0;
            end
            if (acc && i_op == xcf_pkg::OP_FORGET) begin
                r_synced <= 1'b0;
            end
            if (store) begin
                r_cnt <= fin ? '0 : len_now;
            end
            // keystream request already issued for this block
            if (ks_req.start) begin
                r_rdv <= 1'b1;
            end else if (ks_rsp.done) begin
                r_rdv <= 1'b0;
            end
            if (fin) begin
                r_err <= bad_len || (i_op == xcf_pkg::OP_OPEN && win_bad);
                if (!bad_len && i_op == xcf_pkg::OP_SEAL) begin
                    r_send <= r_send + 1'b1;
                end
                if (!bad_len && i_op == xcf_pkg::OP_OPEN && !win_bad) begin
                    r_recv   <= open_ctr;
                    r_synced <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store && r_cnt == '0) begin
            r_first <= i_data_byte;
        end
        if (fin) begin
            r_errst <= bad_len ? xcf_pkg::ST_BADLEN : xcf_pkg::ST_REPLAY;
            r_open  <= (i_op == xcf_pkg::OP_OPEN);
            r_ctr   <= (i_op == xcf_pkg::OP_SEAL) ? r_send : open_ctr;
            r_len   <= (i_op == xcf_pkg::OP_SEAL) ? len_now : len_now - 1'b1;
            r_idx   <= (i_op == xcf_pkg::OP_SEAL) ? CW'(0) : CW'(1);
            r_ksi   <= 3'd0;
        end
        if (ks_rsp.done) begin
            r_ks  <= ks_rsp.ks;
            r_ctr <= r_ctr + 1'b1;
        end
        if (r_state == xcf_pkg::S_EMIT && !r_err) begin
            r_idx <= r_idx + 1'b1;
            r_ksi <= r_ksi + 1'b1;
        end
    end

    `XFC_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy,
        "result strobe while idle")
    `XFC_ASSERT_IMP(a_err_last, i_clk, i_rst_n, o_valid && o_status != xcf_pkg::ST_OK,
        o_out_last && o_out_byte == 8'd0, "error result malformed")
    `XFC_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_valid && o_out_last,
        !busy, "unit stays busy after last result")
    `XFC_ASSERT_IMP(a_idx_range, i_clk, i_rst_n,
        r_state == xcf_pkg::S_EMIT && !r_err, r_idx <= last_idx, "read past frame end")
endmodule

[tb/sv/tb_xxtea_ctr_frame_crypt_unit.sv]
// testbench for the xxtea counter-mode frame unit: directed table, then random frames
`timescale 1ns / 1ps
module tb_xxtea_ctr_frame_crypt_unit;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int QUIET_CYCLES = 260;

    typedef struct {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
    } t_result;

    // one directed row: reps bytes of op, frame end on the last one if fend
    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        int         reps;
        logic       fend;
        logic       typed;
        t_result    res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = xcf_pkg::OP_SEAL;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_frame_end = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [39:0] i_cfg_wdata = 40'd0;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic [1:0]  o_status;

    // predictor state
    logic [31:0] key_w [4];
    logic [31:0] tx_ctr;
    logic [31:0] rx_ctr;
    logic        rx_synced;
    logic [7:0]  frame_buf [32];
    int unsigned held;

    t_result expected_q [$];
    int mismatches = 0;
    int accepted = 0;

    xxtea_ctr_frame_crypt_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_data_byte(i_data_byte), .i_frame_end(i_frame_end),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_valid(o_valid),
        .o_out_byte(o_out_byte), .o_out_last(o_out_last), .o_status(o_status)
    );

    always #1 i_clk = ~i_clk;

    function automatic void set_key(input logic [39:0] addr);
        int idx;
        for (int i = 0; i < 16; i++) begin
            idx = i % 5;
            key_w[i >> 2][8 * (3 - (i & 3)) +: 8] = addr[8 * (4 - idx) +: 8];
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [31:0] y, input logic [31:0] z,
                                            input logic [31:0] s, input logic [31:0] k);
        return (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^ ((s ^ y) + (k ^ z));
    endfunction

    function automatic logic [63:0] ks_block(input logic [31:0] ctr);
        logic [31:0] v0, v1, s, e;
        v0 = ctr;
        v1 = ~ctr;
        s = 32'd0;
        for (int r = 0; r < xcf_pkg::ROUNDS; r++) begin
            s = s + xcf_pkg::DELTA;
            e = (s >> 2) & 32'd3;
            v0 = v0 + round_f(v1, v1, s, key_w[e]);
            v1 = v1 + round_f(v0, v0, s, key_w[1 ^ e]);
        end
        return {v0, v1};
    endfunction

    function automatic void push_crypt(input int first, input int len, input logic [31:0] ctr);
        logic [63:0] ks;
        t_result r;
        for (int i = 0; i < len; i++) begin
            if ((i & 7) == 0) begin
                ks = ks_block(ctr);
                ctr = ctr + 1;
            end
            r.out_byte = frame_buf[(first + i) % 32] ^ ks[8 * (7 - (i & 7)) +: 8];
            r.out_last = (i + 1 == len);
            r.status = xcf_pkg::ST_OK;
            expected_q.push_back(r);
        end
    endfunction

    function automatic void push_error(input logic [1:0] code);
        t_result r;
        r.out_byte = 8'd0;
        r.out_last = 1'b1;
        r.status = code;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_request(input logic [1:0] op, input logic [7:0] data,
                                            input logic fend);
        int unsigned len;
        logic [31:0] ctr;
        logic [7:0] cb, diff;
        t_result r;
        if (op == xcf_pkg::OP_FORGET) begin
            rx_synced = 1'b0;
            return;
        end
        if (op == OP_IGNORED)
            return;
        if (held < 32) begin
            frame_buf[held] = data;
            held++;
        end else begin
            held = 33;
        end
        if (!fend)
            return;
        len = held;
        held = 0;
        if (op == xcf_pkg::OP_SEAL) begin
            if (len < 2 || len > 31) begin
                push_error(xcf_pkg::ST_BADLEN);
                return;
            end
            r.out_byte = tx_ctr[7:0];
            r.out_last = 1'b0;
            r.status = xcf_pkg::ST_OK;
            expected_q.push_back(r);
            push_crypt(0, len, tx_ctr);
            tx_ctr = tx_ctr + 1;
            return;
        end
        if (len < 3 || len > 32) begin
            push_error(xcf_pkg::ST_BADLEN);
            return;
        end
        cb = frame_buf[0];
        if (!rx_synced) begin
            ctr = {24'd0, cb};
        end else begin
            diff = cb - rx_ctr[7:0];
            if (diff == 8'd0 || diff > 8'd32) begin
                push_error(xcf_pkg::ST_REPLAY);
                return;
            end
            ctr = {rx_ctr[31:8], cb};
            if (cb < rx_ctr[7:0])
                ctr = ctr + 32'd256;
        end
        push_crypt(1, len - 1, ctr);
        rx_ctr = ctr;
        rx_synced = 1'b1;
    endfunction

    // sender gaps: mostly none or short, a few long
    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 55) begin
            start <= 1'b0;
            if (r < 92)
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            else
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
        end
    endtask

    // drive one request and wait until it is taken
    task automatic put_request(input logic [1:0] op, input logic [7:0] data, input logic fend);
        start <= 1'b1;
        i_op <= op;
        i_data_byte <= data;
        i_frame_end <= fend;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_request(op, data, fend);
        if (op != OP_IGNORED)
            accepted++;
    endtask

    task automatic send_request(input logic [1:0] op, input logic [7:0] data, input logic fend);
        put_request(op, data, fend);
        idle_gap();
    endtask

    task automatic write_address(input logic [39:0] addr);
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= addr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_key(addr);
        tx_ctr = 32'd0;
        rx_ctr = 32'd0;
        rx_synced = 1'b0;
    endtask

    function automatic int pick_len(input int lo, input int hi, input int top);
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(lo, top))
                                           : int'($urandom_range(lo, hi));
    endfunction

    task automatic random_frames(input int count);
        int goal, r, len;
        logic [1:0] op;
        logic [7:0] b;
        goal = accepted + count;
        while (accepted < goal) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                op = (r < 42) ? xcf_pkg::OP_SEAL : xcf_pkg::OP_OPEN;
                len = (op == xcf_pkg::OP_SEAL) ? pick_len(2, 8, 34) : pick_len(3, 9, 35);
                if ($urandom_range(0, 19) == 0)
                    len = int'($urandom_range(1, 2));
                for (int k = 0; k < len; k++) begin
                    b = 8'($urandom_range(0, 255));
                    // mostly a counter byte inside the window
                    if (k == 0 && op == xcf_pkg::OP_OPEN && $urandom_range(0, 4) != 0)
                        b = 8'(rx_ctr[7:0] + 8'($urandom_range(1, 32)));
                    if (k != 0 && $urandom_range(0, 39) == 0)
                        send_request($urandom_range(0, 1) ? xcf_pkg::OP_FORGET : OP_IGNORED,
                                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    // odd byte of the other op inside the frame
                    if (k + 1 < len && $urandom_range(0, 29) == 0)
                        send_request(op ^ 2'd1, b, 1'b0);
                    else
                        send_request(op, b, k + 1 == len);
                end
            end else begin
                send_request((r < 94) ? xcf_pkg::OP_FORGET : OP_IGNORED,
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // results cannot be held off: compare each strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %02h last %0b status %0d",
                             o_out_byte, o_out_last, o_status);
            end else begin
                e = expected_q.pop_front();
                if (o_out_byte !== e.out_byte || o_out_last !== e.out_last
                        || o_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                                 e.out_byte, e.out_last, e.status,
                                 o_out_byte, o_out_last, o_status);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_row rows [$];
        t_row w;
        rows = '{
            '{xcf_pkg::OP_SEAL, 8'h00, 1, 1'b1, 1'b1, '{8'h00, 1'b1, xcf_pkg::ST_BADLEN}},
            '{xcf_pkg::OP_SEAL, 8'h00, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_SEAL, 8'hFF, 1, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h7E, 2, 1'b1, 1'b1, '{8'h00, 1'b1, xcf_pkg::ST_BADLEN}},
            '{xcf_pkg::OP_OPEN, 8'h10, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'hA5, 3, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h10, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h5A, 2, 1'b1, 1'b1, '{8'h00, 1'b1, xcf_pkg::ST_REPLAY}},
            '{xcf_pkg::OP_OPEN, 8'h30, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_SEAL, 8'h33, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{OP_IGNORED,       8'hFF, 1, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'hC3, 30, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h51, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h00, 2, 1'b1, 1'b1, '{8'h00, 1'b1, xcf_pkg::ST_REPLAY}},
            '{xcf_pkg::OP_FORGET, 8'h00, 1, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'hF0, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h0F, 2, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h0A, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h55, 5, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_SEAL, 8'hAB, 40, 1'b1, 1'b1, '{8'h00, 1'b1, xcf_pkg::ST_BADLEN}},
            '{xcf_pkg::OP_SEAL, 8'h12, 31, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_SEAL, 8'h80, 32, 1'b1, 1'b1, '{8'h00, 1'b1, xcf_pkg::ST_BADLEN}},
            '{xcf_pkg::OP_OPEN, 8'h40, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_FORGET, 8'h00, 1, 1'b0, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'h22, 2, 1'b1, 1'b0, '{8'h00, 1'b0, xcf_pkg::ST_OK}},
            '{xcf_pkg::OP_OPEN, 8'hEE, 36, 1'b1, 1'b1, '{8'h00, 1'b1, xcf_pkg::ST_BADLEN}}
        };
        set_key(40'd0);
        tx_ctr = 32'd0;
        rx_ctr = 32'd0;
        rx_synced = 1'b0;
        held = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) begin
            w = rows[n];
            for (int k = 0; k < w.reps; k++) begin
                put_request(w.op, w.data + 8'(k * 29), w.fend && (k + 1 == w.reps));
                // rows with an obvious answer replace the predicted one before it is due
                if (w.typed && k + 1 == w.reps)
                    expected_q[expected_q.size() - 1] = w.res;
                idle_gap();
            end
        end

        write_address(40'hFF_FFFF_FFFF);
        random_frames(35);
        write_address(40'd0);
        random_frames(30);
        write_address({8'($urandom_range(0, 255)), $urandom});
        random_frames(35);
        write_address(40'h01_0203_0405);
        random_frames(30);

        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
